FILE: rtl/fer_pkg.sv
// Shared types and constants for the fisheye remap coordinate block.
// CORDIC arctangent table in Q.20, register indexes, reset values, item sideband.
// No dependencies.
package fer_pkg;

	localparam int CORDIC_STAGES = 20;

	localparam logic signed [21:0] ATAN_Q20 [CORDIC_STAGES] = '{
		22'sd823550, 22'sd486170, 22'sd256879, 22'sd130396, 22'sd65451,
		22'sd32757, 22'sd16383, 22'sd8192, 22'sd4096, 22'sd2048,
		22'sd1024, 22'sd512, 22'sd256, 22'sd128, 22'sd64,
		22'sd32, 22'sd16, 22'sd8, 22'sd4, 22'sd2
	};

	localparam logic signed [27:0] CORDIC_X0 = 28'sd1048576;

	typedef enum logic [2:0] {
		REG_FOCAL_X,
		REG_FOCAL_Y,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_COEF_CUBIC,
		REG_COEF_SQUARE,
		REG_COEF_LINEAR,
		REG_COEF_OFFSET
	} fer_reg_t;

	localparam logic [15:0] FOCAL_X_RST = 16'd21120;
	localparam logic [15:0] FOCAL_Y_RST = 16'd21120;
	localparam logic [14:0] CENTER_X_RST = 15'd10240;
	localparam logic [14:0] CENTER_Y_RST = 15'd5760;
	localparam logic signed [23:0] COEF_CUBIC_RST = -24'sd115714;
	localparam logic signed [23:0] COEF_SQUARE_RST = 24'sd89681;
	localparam logic signed [23:0] COEF_LINEAR_RST = 24'sd1301587;
	localparam logic signed [23:0] COEF_OFFSET_RST = 24'sd1636;

	typedef struct packed {
		logic [10:0] col;
		logic [9:0]  row;
		logic [21:0] daddr;
	} fer_item_t;

endpackage

FILE: rtl/fisheye_remap_coordinate.sv
// Fisheye undistortion remap: destination pixel to source pixel and RGB addresses.
// Uses fer_pkg, fer_div (normalize and rescale divides) and fer_sqrt (radius).
//
// Input channel: in_valid / in_stall with dest_col, dest_row. Output channel:
// out_valid / out_stall with src_col, src_row, src_valid, src_byte_addr and
// dest_byte_addr. A word moves at a clock edge with valid high and stall low.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no word is in flight.
// Pipeline stages from input word to output word: input stage 1,
// normalize divide 24 (one quotient bit per stage), saturate/square/sum 3,
// square root 24, CORDIC arctangent 20, polynomial and scale products 5,
// rescale divide 30, offset and bounds 3, output register 1.
// Throughput is one word per clock while the output is not stalled: a new word enters every cycle.
// While the receiver stalls a valid output word, the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
// Reset (arst_n low) clears all pipeline valid bits and loads the default
// lens registers; out_valid is low after reset.
// An invalid source gives zero column, row and source address.
module fisheye_remap_coordinate
	import fer_pkg::*;
#(
	parameter int FRAME_WIDTH  = 1280,
	parameter int FRAME_HEIGHT = 720
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [10:0] dest_col,
	input  logic [9:0]  dest_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] src_col,
	output logic [9:0]  src_row,
	output logic        src_valid,
	output logic [21:0] src_byte_addr,
	output logic [21:0] dest_byte_addr,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam logic [27:0] FW_C = 28'(FRAME_WIDTH);
	localparam logic signed [22:0] FW_S = 23'(FRAME_WIDTH);
	localparam logic signed [22:0] FH_S = 23'(FRAME_HEIGHT);
	localparam int DU_SW = 2 + $bits(fer_item_t);
	localparam int DP_SW = 2 + $bits(fer_item_t);

	typedef struct packed {
		logic [23:0]        r;
		logic signed [23:0] u;
		logic signed [23:0] v;
		fer_item_t          item;
	} cside_t;

	localparam int SQ_SW = 48 + $bits(fer_item_t);

	function automatic logic [21:0] rgb_addr(input logic [11:0] row, input logic [11:0] col);
		logic [27:0] pix;
		pix = 28'(row) * FW_C + 28'(col);
		return 22'(pix + {pix[26:0], 1'b0});
	endfunction

	function automatic logic signed [23:0] sat_q(input logic neg, input logic ovf,
		input logic [23:0] q);
		if (neg) begin
			return (ovf || q > 24'h800000) ? 24'h800000 : 24'(~q + 24'd1);
		end
		return (ovf || q[23]) ? 24'h7FFFFF : q;
	endfunction

	function automatic logic signed [22:0] trunc16(input logic signed [26:0] s);
		logic signed [26:0] m;
		m = s[26] ? -s : s;
		m = m >>> 4;
		return 23'(s[26] ? -m : m);
	endfunction

	logic [15:0]        focal_x_q, focal_y_q;
	logic [14:0]        center_x_q, center_y_q;
	logic signed [23:0] coef_cubic_q, coef_square_q, coef_linear_q, coef_offset_q;
	logic [15:0]        fxe, fye;
	logic               adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q     <= FOCAL_X_RST;
			focal_y_q     <= FOCAL_Y_RST;
			center_x_q    <= CENTER_X_RST;
			center_y_q    <= CENTER_Y_RST;
			coef_cubic_q  <= COEF_CUBIC_RST;
			coef_square_q <= COEF_SQUARE_RST;
			coef_linear_q <= COEF_LINEAR_RST;
			coef_offset_q <= COEF_OFFSET_RST;
		end else if (cfg_valid) begin
			case (fer_reg_t'(cfg_index))
				REG_FOCAL_X:     focal_x_q     <= cfg_data[15:0];
				REG_FOCAL_Y:     focal_y_q     <= cfg_data[15:0];
				REG_CENTER_X:    center_x_q    <= cfg_data[14:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[14:0];
				REG_COEF_CUBIC:  coef_cubic_q  <= cfg_data;
				REG_COEF_SQUARE: coef_square_q <= cfg_data;
				REG_COEF_LINEAR: coef_linear_q <= cfg_data;
				REG_COEF_OFFSET: coef_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fxe = (focal_x_q == '0) ? 16'd1 : focal_x_q;
	assign fye = (focal_y_q == '0) ? 16'd1 : focal_y_q;

	logic out_vld_q;

	assign adv      = !(out_vld_q && out_stall);
	assign in_stall = !adv;

	// stage 1: capture, center offsets, destination address
	logic               vld_s1;
	logic signed [16:0] dx_s1, dy_s1;
	fer_item_t          item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1        <= $signed({2'b00, dest_col, 4'b0000}) - $signed({2'b00, center_x_q});
			dy_s1        <= $signed({3'b000, dest_row, 4'b0000}) - $signed({2'b00, center_y_q});
			item_s1.col  <= dest_col;
			item_s1.row  <= dest_row;
			item_s1.daddr <= rgb_addr(12'(dest_row), 12'(dest_col));
		end
	end

	// normalize: |d| * 2^22 / focal
	logic [14:0] adx, ady;
	logic        ovfx, ovfy;

	always_comb begin
		adx  = dx_s1[16] ? 15'(-dx_s1) : dx_s1[14:0];
		ady  = dy_s1[16] ? 15'(-dy_s1) : dy_s1[14:0];
		ovfx = 16'(adx[14:2]) >= fxe;
		ovfy = 16'(ady[14:2]) >= fye;
	end

	logic        du_vld, du_neg, du_ovf, dv_neg, dv_ovf;
	logic [23:0] du_q, dv_q;
	fer_item_t   du_item;

	fer_div #(.DW(16), .QW(24), .SW(DU_SW)) u_div_u (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s1),
		.rem_i  (ovfx ? 16'd0 : 16'(adx[14:2])),
		.num_i  ({adx[1:0], 22'd0}),
		.den_i  (fxe),
		.side_i ({dx_s1[16], ovfx, item_s1}),
		.vld_o  (du_vld),
		.quo_o  (du_q),
		.side_o ({du_neg, du_ovf, du_item})
	);

	fer_div #(.DW(16), .QW(24), .SW(2)) u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s1),
		.rem_i  (ovfy ? 16'd0 : 16'(ady[14:2])),
		.num_i  ({ady[1:0], 22'd0}),
		.den_i  (fye),
		.side_i ({dy_s1[16], ovfy}),
		.vld_o  (),
		.quo_o  (dv_q),
		.side_o ({dv_neg, dv_ovf})
	);

	// stages 2-4: saturate, square, sum
	logic               vld_s2, vld_s3, vld_s4;
	logic signed [23:0] u_s2, v_s2, u_s3, v_s3, u_s4, v_s4;
	logic signed [47:0] uu_s3, vv_s3;
	logic [47:0]        n_s4;
	fer_item_t          item_s2, item_s3, item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= du_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2    <= sat_q(du_neg, du_ovf, du_q);
			v_s2    <= sat_q(dv_neg, dv_ovf, dv_q);
			item_s2 <= du_item;
			uu_s3   <= u_s2 * u_s2;
			vv_s3   <= v_s2 * v_s2;
			u_s3    <= u_s2;
			v_s3    <= v_s2;
			item_s3 <= item_s2;
			n_s4    <= $unsigned(uu_s3) + $unsigned(vv_s3);
			u_s4    <= u_s3;
			v_s4    <= v_s3;
			item_s4 <= item_s3;
		end
	end

	// radius
	logic               sq_vld;
	logic [23:0]        sq_r;
	logic signed [23:0] sq_u, sq_v;
	fer_item_t          sq_item;

	fer_sqrt #(.RW(24), .SW(SQ_SW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s4),
		.n_i    (n_s4),
		.side_i ({u_s4, v_s4, item_s4}),
		.vld_o  (sq_vld),
		.root_o (sq_r),
		.side_o ({sq_u, sq_v, sq_item})
	);

	// CORDIC vectoring: theta = atan(r)
	logic               cvld_s  [0:CORDIC_STAGES];
	logic signed [27:0] cx_s    [0:CORDIC_STAGES];
	logic signed [27:0] cy_s    [0:CORDIC_STAGES];
	logic signed [21:0] cz_s    [0:CORDIC_STAGES];
	cside_t             cside_s [0:CORDIC_STAGES];

	assign cvld_s[0]  = sq_vld;
	assign cx_s[0]    = CORDIC_X0;
	assign cy_s[0]    = $signed({4'b0000, sq_r});
	assign cz_s[0]    = '0;
	assign cside_s[0] = '{r: sq_r, u: sq_u, v: sq_v, item: sq_item};

	for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cordic
		logic signed [27:0] xs, ys;
		logic               pos;

		always_comb begin
			xs  = cx_s[k-1] >>> (k - 1);
			ys  = cy_s[k-1] >>> (k - 1);
			pos = !cy_s[k-1][27] && (cy_s[k-1] != '0);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s[k] <= 1'b0;
			end else if (adv) begin
				cvld_s[k] <= cvld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cx_s[k]    <= pos ? cx_s[k-1] + ys : cx_s[k-1] - ys;
				cy_s[k]    <= pos ? cy_s[k-1] - xs : cy_s[k-1] + xs;
				cz_s[k]    <= pos ? cz_s[k-1] + ATAN_Q20[k-1] : cz_s[k-1] - ATAN_Q20[k-1];
				cside_s[k] <= cside_s[k-1];
			end
		end
	end

	// stages 5-9: Horner polynomial, magnitudes of u*rd and v*rd
	logic               vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic signed [21:0] t_s5, t_s6;
	logic signed [45:0] m1_s5;
	logic signed [48:0] m2_s6;
	logic signed [51:0] m3_s7;
	logic signed [30:0] rd_s8;
	cside_t             cs_s5, cs_s6, cs_s7, cs_s8;
	logic [52:0]        pu_s9, pv_s9;
	logic               negu_s9, negv_s9, r0_s9;
	logic [23:0]        r_s9;
	fer_item_t          item_s9;
	logic signed [26:0] a1;
	logic signed [29:0] a2;
	logic [28:0]        ard;
	logic [23:0]        au, av;

	always_comb begin
		a1  = 27'(m1_s5 >>> 20) + 27'(coef_square_q);
		a2  = 30'(m2_s6 >>> 20) + 30'(coef_linear_q);
		ard = rd_s8[30] ? 29'(-rd_s8) : rd_s8[28:0];
		au  = cs_s8.u[23] ? 24'(-cs_s8.u) : cs_s8.u;
		av  = cs_s8.v[23] ? 24'(-cs_s8.v) : cs_s8.v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= cvld_s[CORDIC_STAGES];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s5   <= coef_cubic_q * cz_s[CORDIC_STAGES];
			t_s5    <= cz_s[CORDIC_STAGES];
			cs_s5   <= cside_s[CORDIC_STAGES];
			m2_s6   <= a1 * t_s5;
			t_s6    <= t_s5;
			cs_s6   <= cs_s5;
			m3_s7   <= a2 * t_s6;
			cs_s7   <= cs_s6;
			rd_s8   <= 31'(m3_s7 >>> 20) + 31'(coef_offset_q);
			cs_s8   <= cs_s7;
			pu_s9   <= 53'(au) * 53'(ard);
			pv_s9   <= 53'(av) * 53'(ard);
			negu_s9 <= cs_s8.u[23] ^ rd_s8[30];
			negv_s9 <= cs_s8.v[23] ^ rd_s8[30];
			r0_s9   <= cs_s8.r == '0;
			r_s9    <= cs_s8.r;
			item_s9 <= cs_s8.item;
		end
	end

	// rescale: u*rd / r
	logic        dp_vld, dp_negu, dp_r0, dp_negv;
	logic [29:0] dp_qu, dp_qv;
	fer_item_t   dp_item;

	fer_div #(.DW(24), .QW(30), .SW(DP_SW)) u_div_pu (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s9),
		.rem_i  ({1'b0, pu_s9[52:30]}),
		.num_i  (pu_s9[29:0]),
		.den_i  (r_s9),
		.side_i ({negu_s9, r0_s9, item_s9}),
		.vld_o  (dp_vld),
		.quo_o  (dp_qu),
		.side_o ({dp_negu, dp_r0, dp_item})
	);

	fer_div #(.DW(24), .QW(30), .SW(1)) u_div_pv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s9),
		.rem_i  ({1'b0, pv_s9[52:30]}),
		.num_i  (pv_s9[29:0]),
		.den_i  (r_s9),
		.side_i (negv_s9),
		.vld_o  (),
		.quo_o  (dp_qv),
		.side_o (dp_negv)
	);

	// stages 10-12: sign, focal scale, truncate and bounds
	logic               vld_s10, vld_s11, vld_s12;
	logic signed [30:0] pu_s10, pv_s10;
	logic signed [47:0] ox_s11, oy_s11;
	logic               r0_s10, r0_s11;
	fer_item_t          item_s10, item_s11;
	logic signed [22:0] sc_s12, sr_s12;
	logic               ok_s12;
	logic [21:0]        daddr_s12;
	logic signed [26:0] sxw, syw;
	logic signed [22:0] scn, srn;

	always_comb begin
		sxw = $signed({12'd0, center_x_q}) + 27'(ox_s11 >>> 22);
		syw = $signed({12'd0, center_y_q}) + 27'(oy_s11 >>> 22);
		if (r0_s11) begin
			scn = $signed({12'd0, item_s11.col});
			srn = $signed({13'd0, item_s11.row});
		end else begin
			scn = trunc16(sxw);
			srn = trunc16(syw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s10 <= dp_vld;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s10    <= dp_negu ? -$signed({1'b0, dp_qu}) : $signed({1'b0, dp_qu});
			pv_s10    <= dp_negv ? -$signed({1'b0, dp_qv}) : $signed({1'b0, dp_qv});
			r0_s10    <= dp_r0;
			item_s10  <= dp_item;
			ox_s11    <= pu_s10 * $signed({1'b0, fxe});
			oy_s11    <= pv_s10 * $signed({1'b0, fye});
			r0_s11    <= r0_s10;
			item_s11  <= item_s10;
			sc_s12    <= scn;
			sr_s12    <= srn;
			ok_s12    <= !scn[22] && !srn[22] && (scn < FW_S) && (srn < FH_S);
			daddr_s12 <= item_s11.daddr;
		end
	end

	// output register
	logic [10:0] src_col_q;
	logic [9:0]  src_row_q;
	logic        src_valid_q;
	logic [21:0] src_addr_q, dest_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_col_q   <= ok_s12 ? sc_s12[10:0] : '0;
			src_row_q   <= ok_s12 ? sr_s12[9:0] : '0;
			src_valid_q <= ok_s12;
			src_addr_q  <= ok_s12 ? rgb_addr(sr_s12[11:0], sc_s12[11:0]) : '0;
			dest_addr_q <= daddr_s12;
		end
	end

	assign out_valid      = out_vld_q;
	assign src_col        = src_col_q;
	assign src_row        = src_row_q;
	assign src_valid      = src_valid_q;
	assign src_byte_addr  = src_addr_q;
	assign dest_byte_addr = dest_addr_q;

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !src_valid |-> src_col == '0 && src_row == '0 && src_byte_addr == '0)
		else $error("invalid source word carries nonzero coordinates");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_s12) && $stable(sc_s12) && $stable(sr_s12))
		else $error("pipeline advanced while output stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_s1) && $stable(dx_s1))
		else $error("input stage changed while stalled");
`endif

endmodule

FILE: rtl/fer_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Dividend is {rem_i, num_i} with rem_i below den_i; sideband travels along.
// No package dependencies.
module fer_div #(
	parameter int DW = 16,
	parameter int QW = 24,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [QW-1:0] quo_o,
	output logic [SW-1:0] side_o
);

	logic          vld_s  [0:QW];
	logic [DW-1:0] rem_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];

	assign vld_s[0]  = vld_i;
	assign rem_s[0]  = rem_i;
	assign quo_s[0]  = num_i;
	assign den_s[0]  = den_i;
	assign side_s[0] = side_i;

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[k-1], quo_s[k-1][QW-1]};
			ge    = trial >= {1'b0, den_s[k-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(trial - {1'b0, den_s[k-1]}) : trial[DW-1:0];
				quo_s[k]  <= {quo_s[k-1][QW-2:0], ge};
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign vld_o  = vld_s[QW];
	assign quo_o  = quo_s[QW];
	assign side_o = side_s[QW];

endmodule

FILE: rtl/fer_sqrt.sv
// Pipelined integer square root (floor), one root bit per stage.
// Radicand of 2*RW bits; sideband travels along.
// No package dependencies.
module fer_sqrt #(
	parameter int RW = 24,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*RW-1:0] n_i,
	input  logic [SW-1:0]   side_i,
	output logic            vld_o,
	output logic [RW-1:0]   root_o,
	output logic [SW-1:0]   side_o
);

	logic            vld_s  [0:RW];
	logic [RW+1:0]   rem_s  [0:RW];
	logic [RW-1:0]   root_s [0:RW];
	logic [2*RW-1:0] rad_s  [0:RW];
	logic [SW-1:0]   side_s [0:RW];

	assign vld_s[0]  = vld_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = n_i;
	assign side_s[0] = side_i;

	for (genvar k = 1; k <= RW; k++) begin : g_step
		logic [RW+3:0] trial;
		logic [RW+3:0] cand;
		logic          ge;

		always_comb begin
			trial = {rem_s[k-1], rad_s[k-1][2*RW-1:2*RW-2]};
			cand  = {2'b00, root_s[k-1], 2'b01};
			ge    = trial >= cand;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (RW+2)'(trial - cand) : trial[RW+1:0];
				root_s[k] <= {root_s[k-1][RW-2:0], ge};
				rad_s[k]  <= {rad_s[k-1][2*RW-3:0], 2'b00};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign vld_o  = vld_s[RW];
	assign root_o = root_s[RW];
	assign side_o = side_s[RW];

endmodule
